@@ rtl/core/dmptlb_pkg.sv @@
package dmptlb_pkg;
  localparam int VADDR_BITS_DEF    = 22;
  localparam int PAGE_SHIFT_DEF    = 12;
  localparam int DYNAMIC_SLOTS_DEF = 16;
  localparam int FIXED_SLOTS_DEF   = 8;

  localparam int REQ_W   = 3;
  localparam int INT_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 11;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int DC_W    = 5;
  localparam logic [DC_W-1:0] DC_RESET = 5'd16;

  localparam logic [DATA_W-1:0] PTE_FLAGS_MASK = 32'h0000_00FF;
  localparam logic [DATA_W-1:0] PTE_VALID      = 32'h0000_0080;
  localparam logic [DATA_W-1:0] PTE_FIXED      = 32'h0000_0040;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_LOAD   = 3'd2,
    REQ_FLUSHD = 3'd3,
    REQ_FLUSHP = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSLOT  = 2'd1,
    ST_XLFAIL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD, S_EXEC, S_FLUSH, S_UNLOAD, S_LOADW, S_FINAL, S_FINRD, S_OUT
  } state_t;

  typedef struct packed {
    logic cap;
    logic clr_step;
    logic exec;
    logic flush_step;
    logic unload_step;
    logic load_step;
    logic final_rd;
    logic final_cap;
    logic out_valid;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic load_req;
    logic load_ok;
    logic flush_req;
    logic flush_done;
    logic unload_done;
    logic load_done;
  } ctl_stat_t;
endpackage

@@ rtl/core/dmptlb_in_if.sv @@
interface dmptlb_in_if #(parameter int VADDR_BITS = dmptlb_pkg::VADDR_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic [dmptlb_pkg::REQ_W-1:0]  req_type;
  logic [VADDR_BITS-1:0]         virt_address;
  logic [dmptlb_pkg::INT_W-1:0]  intention;
  logic                          translate_ok;
  logic [dmptlb_pkg::DATA_W-1:0] phys_address;
  logic [dmptlb_pkg::SLOT_W-1:0] fixed_slot;
  logic [dmptlb_pkg::CNT_W-1:0]  page_count;
  logic [dmptlb_pkg::DATA_W-1:0] load_value;
  modport source (output valid, req_type, virt_address, intention, translate_ok,
                  phys_address, fixed_slot, page_count, load_value, input ready);
  modport sink (input valid, req_type, virt_address, intention, translate_ok,
                phys_address, fixed_slot, page_count, load_value, output ready);
endinterface

@@ rtl/core/dmptlb_out_if.sv @@
interface dmptlb_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmptlb_pkg::STAT_W-1:0] status;
  logic [dmptlb_pkg::DATA_W-1:0] entry_out;
  modport source (output valid, status, entry_out, input ready);
  modport sink (input valid, status, entry_out, output ready);
endinterface

@@ rtl/core/dmptlb_ctrl.sv @@
module dmptlb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  input  dmptlb_pkg::ctl_stat_t stat,
  output dmptlb_pkg::ctl_cmd_t  cmd
);
  import dmptlb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_RD;
      S_RD:     state_nxt = S_EXEC;
      S_EXEC: begin
        if (stat.flush_req) state_nxt = S_FLUSH;
        else if (stat.load_req && stat.load_ok) state_nxt = S_UNLOAD;
        else state_nxt = S_FINAL;
      end
      S_FLUSH:  if (stat.flush_done) state_nxt = S_FINAL;
      S_UNLOAD: if (stat.unload_done) state_nxt = S_LOADW;
      S_LOADW:  if (stat.load_done) state_nxt = S_FINAL;
      S_FINAL:  state_nxt = S_FINRD;
      S_FINRD:  state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap = in_valid;
      end
      S_RD:     ;
      S_EXEC:   cmd.exec = 1'b1;
      S_FLUSH:  cmd.flush_step = 1'b1;
      S_UNLOAD: cmd.unload_step = 1'b1;
      S_LOADW:  cmd.load_step = 1'b1;
      S_FINAL:  cmd.final_rd = 1'b1;
      S_FINRD:  cmd.final_cap = 1'b1;
      S_OUT:    cmd.out_valid = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule

@@ rtl/core/dmptlb_dp.sv @@
module dmptlb_dp #(
  parameter int VADDR_BITS    = dmptlb_pkg::VADDR_BITS_DEF,
  parameter int PAGE_SHIFT    = dmptlb_pkg::PAGE_SHIFT_DEF,
  parameter int DYNAMIC_SLOTS = dmptlb_pkg::DYNAMIC_SLOTS_DEF,
  parameter int FIXED_SLOTS   = dmptlb_pkg::FIXED_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dmptlb_pkg::ctl_cmd_t          cmd,
  output dmptlb_pkg::ctl_stat_t         stat,
  input  logic                          cfg_we,
  input  logic [dmptlb_pkg::DC_W-1:0]   cfg_wdata,
  input  logic [dmptlb_pkg::REQ_W-1:0]  req_type,
  input  logic [VADDR_BITS-1:0]         virt_address,
  input  logic [dmptlb_pkg::INT_W-1:0]  intention,
  input  logic                          translate_ok,
  input  logic [dmptlb_pkg::DATA_W-1:0] phys_address,
  input  logic [dmptlb_pkg::SLOT_W-1:0] fixed_slot,
  input  logic [dmptlb_pkg::CNT_W-1:0]  page_count,
  input  logic [dmptlb_pkg::DATA_W-1:0] load_value,
  output logic [dmptlb_pkg::STAT_W-1:0] status,
  output logic [dmptlb_pkg::DATA_W-1:0] entry_out
);
  import dmptlb_pkg::*;

  localparam int IDX_W   = VADDR_BITS - PAGE_SHIFT;
  localparam int TSIZE   = 1 << IDX_W;
  localparam int SPAN_W  = IDX_W + 1;
  localparam int DS_W    = (DYNAMIC_SLOTS > 1) ? $clog2(DYNAMIC_SLOTS) : 1;
  localparam int DSC_W   = $clog2(DYNAMIC_SLOTS + 1);
  localparam int FS_W    = (FIXED_SLOTS > 1) ? $clog2(FIXED_SLOTS) : 1;
  localparam int DCM_W   = (DSC_W > DC_W) ? DSC_W : DC_W;

  logic [DATA_W-1:0] mem [TSIZE];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd, mem_rd_r;

  // slot owner: valid bit plus page index
  logic             dyn_own_r [DYNAMIC_SLOTS];
  logic [IDX_W-1:0] dyn_pg_r  [DYNAMIC_SLOTS];
  logic             fix_own_r [FIXED_SLOTS];
  logic [IDX_W-1:0] fix_pg_r  [FIXED_SLOTS];
  logic [SPAN_W-1:0] span_r   [FIXED_SLOTS];
  logic [DS_W-1:0]  nxt_slot_r;
  logic [DC_W-1:0]  dc_r;

  logic [REQ_W-1:0]  req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [INT_W-1:0]  int_r;
  logic              ok_r;
  logic [DATA_W-1:0] phys_r, val_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] entry_r;
  logic [SPAN_W-1:0] ctr_r;
  logic [IDX_W-1:0]  base_r;
  logic [SPAN_W-1:0] nspan_r;

  logic [DCM_W-1:0] dc_eff;
  logic             load_ok;
  logic [FS_W-1:0]  fs;
  logic [DS_W-1:0]  s_use;
  logic [DCM_W-1:0] s_inc;
  logic [DATA_W-1:0] new_entry;
  logic [SPAN_W-1:0] n_sat;
  logic [DS_W-1:0]  fl_slot;

  assign dc_eff = (DCM_W'(dc_r) > DCM_W'(DYNAMIC_SLOTS)) ? DCM_W'(DYNAMIC_SLOTS)
                                                          : DCM_W'(dc_r);
  assign load_ok = (32'(slot_r) < 32'(FIXED_SLOTS));
  assign fs = FS_W'(slot_r);
  assign s_use = (DCM_W'(nxt_slot_r) >= dc_eff) ? '0 : nxt_slot_r;
  assign s_inc = DCM_W'(s_use) + DCM_W'(1);
  assign n_sat = (32'(cnt_r) > 32'(TSIZE)) ? SPAN_W'(TSIZE) : SPAN_W'(cnt_r);
  assign fl_slot = DS_W'(ctr_r);

  always_comb begin
    new_entry = mem_rd_r;
    if ((mem_rd_r & PTE_FLAGS_MASK) == '0) begin
      new_entry = ((phys_r >> PAGE_SHIFT) << PAGE_SHIFT) | PTE_VALID;
    end
    new_entry = new_entry | (DATA_W'(1) << int_r);
  end

  assign stat.clr_done    = (ctr_r == SPAN_W'(TSIZE - 1));
  assign stat.load_req    = (req_r == REQ_LOAD);
  assign stat.load_ok     = load_ok;
  assign stat.flush_req   = (req_r == REQ_FLUSHD);
  assign stat.flush_done  = (ctr_r == SPAN_W'(DYNAMIC_SLOTS - 1));
  assign stat.unload_done = (ctr_r >= nspan_r);
  assign stat.load_done   = (ctr_r >= n_sat);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    mem_ra = idx_r;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = IDX_W'(ctr_r);
    end
    if (cmd.exec) begin
      case (req_r)
        REQ_FILL: begin
          if (dc_eff != '0 && ok_r) begin
            mem_we = 1'b1;
            mem_wd = new_entry;
          end
        end
        REQ_FLUSHP: mem_we = 1'b1;
        default: mem_we = 1'b0;
      endcase
    end
    if (cmd.flush_step && dyn_own_r[fl_slot]) begin
      mem_we = 1'b1;
      mem_wa = dyn_pg_r[fl_slot];
    end
    if (cmd.unload_step && ctr_r < nspan_r) begin
      mem_we = 1'b1;
      mem_wa = base_r + IDX_W'(ctr_r);
    end
    if (cmd.load_step && ctr_r < n_sat) begin
      mem_we = 1'b1;
      mem_wa = idx_r + IDX_W'(ctr_r);
      mem_wd = (val_r | PTE_FIXED) + (DATA_W'(ctr_r) << PAGE_SHIFT);
    end
  end

  // the evicted page is cleared in the FINAL step, as the new entry is reread
  logic             evict_pend_r;
  logic [IDX_W-1:0] evict_pg_r;
  logic [DATA_W-1:0] fill_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      nxt_slot_r <= '0;
      dc_r <= DC_RESET;
      evict_pend_r <= 1'b0;
      status_r <= ST_DONE;
      for (int i = 0; i < DYNAMIC_SLOTS; i++) dyn_own_r[i] <= 1'b0;
      for (int i = 0; i < FIXED_SLOTS; i++) begin
        fix_own_r[i] <= 1'b0;
        span_r[i] <= '0;
      end
    end else begin
      if (cfg_we) dc_r <= cfg_wdata;
      if (cmd.clr_step) ctr_r <= ctr_r + SPAN_W'(1);
      if (cmd.cap) begin
        req_r <= req_type;
        idx_r <= IDX_W'(virt_address >> PAGE_SHIFT);
        int_r <= intention;
        ok_r <= translate_ok;
        phys_r <= phys_address;
        val_r <= load_value;
        slot_r <= fixed_slot;
        cnt_r <= page_count;
        ctr_r <= '0;
        status_r <= ST_DONE;
        evict_pend_r <= 1'b0;
      end
      if (cmd.exec) begin
        ctr_r <= '0;
        if (req_r == REQ_FILL) begin
          if (dc_eff == '0) status_r <= ST_NOSLOT;
          else if (!ok_r) status_r <= ST_XLFAIL;
          else if ((mem_rd_r & PTE_FLAGS_MASK) == '0) begin
            nxt_slot_r <= (s_inc >= dc_eff) ? '0 : DS_W'(s_inc);
            dyn_own_r[s_use] <= 1'b1;
            dyn_pg_r[s_use] <= idx_r;
            evict_pend_r <= dyn_own_r[s_use];
            evict_pg_r <= dyn_pg_r[s_use];
            fill_val_r <= new_entry;
          end
        end
        if (req_r == REQ_LOAD && load_ok) begin
          base_r <= fix_pg_r[fs];
          nspan_r <= fix_own_r[fs] ? span_r[fs] : '0;
          fix_own_r[fs] <= 1'b1;
          fix_pg_r[fs] <= idx_r;
          span_r[fs] <= n_sat;
        end
      end
      if (cmd.flush_step) begin
        dyn_own_r[fl_slot] <= 1'b0;
        ctr_r <= ctr_r + SPAN_W'(1);
      end
      if (cmd.unload_step) begin
        ctr_r <= stat.unload_done ? '0 : ctr_r + SPAN_W'(1);
      end
      if (cmd.load_step) ctr_r <= ctr_r + SPAN_W'(1);
      if (cmd.final_rd) evict_pend_r <= 1'b0;
      if (cmd.final_cap) entry_r <= mem_rd_r;
    end
  end

  // eviction write and final reread both happen in FINAL
  logic              fin_we;
  always_comb begin
    fin_we = cmd.final_rd && evict_pend_r;
  end

  logic              w_en;
  logic [IDX_W-1:0]  w_a;
  logic [DATA_W-1:0] w_d;
  always_comb begin
    w_en = mem_we;
    w_a  = mem_wa;
    w_d  = mem_wd;
    if (fin_we) begin
      w_en = 1'b1;
      w_a  = evict_pg_r;
      w_d  = (evict_pg_r == idx_r) ? fill_val_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) mem[w_a] <= w_d;
    mem_rd_r <= mem[mem_ra];
  end

  assign status = status_r;
  assign entry_out = entry_r;
endmodule

@@ rtl/core/direct_mapped_page_table_tlb.sv @@
// Lookup, fill and page flush pass through RD, EXEC, FINAL and FINRD before the result
// is presented in OUT; a dynamic flush adds FLUSH, which walks every dynamic slot, and
// a fixed load adds UNLOAD over the old span and LOADW over the new one. One request is
// in flight: a new one is taken only after the response is accepted. Reset: synchronous
// active-low; the table is then cleared entry by entry in CLEAR, while no request is taken.
module direct_mapped_page_table_tlb #(
  parameter int VADDR_BITS    = dmptlb_pkg::VADDR_BITS_DEF,
  parameter int PAGE_SHIFT    = dmptlb_pkg::PAGE_SHIFT_DEF,
  parameter int DYNAMIC_SLOTS = dmptlb_pkg::DYNAMIC_SLOTS_DEF,
  parameter int FIXED_SLOTS   = dmptlb_pkg::FIXED_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dmptlb_in_if.sink                   in_req,
  dmptlb_out_if.source                out_rsp,
  input  logic                        cfg_we,
  input  logic [dmptlb_pkg::DC_W-1:0] cfg_wdata
);
  import dmptlb_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  dmptlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .out_ready(out_rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmptlb_dp #(
    .VADDR_BITS   (VADDR_BITS),
    .PAGE_SHIFT   (PAGE_SHIFT),
    .DYNAMIC_SLOTS(DYNAMIC_SLOTS),
    .FIXED_SLOTS  (FIXED_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_type    (in_req.req_type),
    .virt_address(in_req.virt_address),
    .intention   (in_req.intention),
    .translate_ok(in_req.translate_ok),
    .phys_address(in_req.phys_address),
    .fixed_slot  (in_req.fixed_slot),
    .page_count  (in_req.page_count),
    .load_value  (in_req.load_value),
    .status      (out_rsp.status),
    .entry_out   (out_rsp.entry_out)
  );

  assign out_rsp.valid = cmd.out_valid;
endmodule

@@ dv/tb.sv @@
module tb;
  import dmptlb_pkg::*;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [21:0]       va;
    logic [INT_W-1:0]  intent;
    logic              xl_ok;
    logic [DATA_W-1:0] phys;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] lval;
  } tlb_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] entry;
  } tlb_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DC_W-1:0] cfg_wdata;

  dmptlb_in_if  in_if();
  dmptlb_out_if out_if();

  direct_mapped_page_table_tlb i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_rsp   (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the table state
  logic [DATA_W-1:0] pg_tbl [1024];
  int unsigned       owner [24];
  int unsigned       span [8];
  int unsigned       next_slot;
  int unsigned       dyn_cnt;

  tlb_rsp_t    rsp_q[$];
  int          fails;
  int          n_sent;
  int          n_checked;
  int          n_big;
  int unsigned idle_pct;
  int unsigned stall_pct;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h (response %0d)", what, got, want, n_checked);
    fails++;
  endtask

  function automatic void drop_owner(input int unsigned s);
    if (owner[s] != 0) pg_tbl[(owner[s] - 1) & 1023] = '0;
  endfunction

  function automatic tlb_rsp_t predict_entry(input tlb_req_t it);
    tlb_rsp_t    r;
    int unsigned idx;
    int unsigned dc;
    int unsigned s;
    int unsigned n;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] v;
    idx = 32'(it.va[21:12]);
    r.status = ST_DONE;
    case (it.req)
      REQ_FILL: begin
        dc = (dyn_cnt > 16) ? 16 : dyn_cnt;
        e = pg_tbl[idx];
        if (dc == 0) r.status = ST_NOSLOT;
        else if (!it.xl_ok) r.status = ST_XLFAIL;
        else begin
          if ((e & PTE_FLAGS_MASK) == 0) begin
            s = next_slot;
            if (s >= dc) s = 0;
            next_slot = (s + 1 >= dc) ? 0 : s + 1;
            drop_owner(s);
            owner[s] = idx + 1;
            e = {it.phys[31:12], 12'b0} | PTE_VALID;
          end
          e |= 32'd1 << it.intent;
          pg_tbl[idx] = e;
        end
      end
      REQ_LOAD: begin
        s = 16 + 32'(it.slot);
        if (owner[s] != 0)
          for (int i = 0; i < span[it.slot]; i++) pg_tbl[(owner[s] - 1 + i) & 1023] = '0;
        n = (it.count > 1024) ? 1024 : 32'(it.count);
        owner[s] = idx + 1;
        span[it.slot] = n;
        v = it.lval | PTE_FIXED;
        for (int i = 0; i < n; i++) pg_tbl[(idx + i) & 1023] = v + 32'(i << 12);
      end
      REQ_FLUSHD: begin
        for (int i = 0; i < 16; i++) begin
          drop_owner(i);
          owner[i] = 0;
        end
      end
      REQ_FLUSHP: pg_tbl[idx] = '0;
      default: ;
    endcase
    r.entry = pg_tbl[idx];
    return r;
  endfunction

  task automatic send_req(input tlb_req_t it);
    int g;
    if ($urandom_range(99) < idle_pct) begin
      g = $urandom_range(1, 5);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.req_type     <= it.req;
    in_if.virt_address <= it.va;
    in_if.intention    <= it.intent;
    in_if.translate_ok <= it.xl_ok;
    in_if.phys_address <= it.phys;
    in_if.fixed_slot   <= it.slot;
    in_if.page_count   <= it.count;
    in_if.load_value   <= it.lval;
    do @(posedge clk); while (!in_if.ready);
    rsp_q.push_back(predict_entry(it));
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_dyn_count(input logic [DC_W-1:0] v);
    drain();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    dyn_cnt = 32'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tlb_req_t mk(input logic [REQ_W-1:0] req, input logic [21:0] va);
    tlb_req_t it;
    it.req = req;
    it.va = va;
    it.intent = INT_W'($urandom);
    it.xl_ok = 1'b1;
    it.phys = $urandom;
    it.slot = SLOT_W'($urandom);
    it.count = CNT_W'($urandom_range(0, 6));
    it.lval = $urandom;
    return it;
  endfunction

  function automatic tlb_req_t rand_req();
    tlb_req_t    it;
    int unsigned k;
    logic [9:0]  pg;
    pg = ($urandom_range(99) < 70) ? 10'($urandom_range(0, 15)) : 10'($urandom);
    k = $urandom_range(99);
    it = mk(REQ_LOOKUP, {pg, 12'($urandom)});
    if (k < 35) begin
      it.req = REQ_FILL;
      it.xl_ok = ($urandom_range(9) != 0);
    end else if (k < 45) begin
      it.req = REQ_LOAD;
      if (n_big < 6 && $urandom_range(49) == 0) begin
        it.count = ($urandom_range(1) != 0) ? 11'd1024 : 11'($urandom_range(1025, 2047));
        n_big++;
      end
    end else if (k < 50) it.req = REQ_FLUSHD;
    else if (k < 65) it.req = REQ_FLUSHP;
    else if (k < 70) it.req = 3'($urandom_range(5, 7));
    return it;
  endfunction

  always @(posedge clk) begin
    tlb_rsp_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (rsp_q.size() == 0) begin
        report("unexpected response", out_if.entry_out, '0);
      end else begin
        w = rsp_q.pop_front();
        if (out_if.status !== w.status)
          report("status", DATA_W'(out_if.status), DATA_W'(w.status));
        if (out_if.entry_out !== w.entry) report("entry", out_if.entry_out, w.entry);
      end
      n_checked++;
    end
  end

  always @(negedge clk) out_if.ready <= !($urandom_range(99) < stall_pct);

  task automatic test_fill_and_lookup();
    tlb_req_t it;
    send_req(mk(REQ_LOOKUP, 22'h0));
    it = mk(REQ_FILL, 22'h000123);
    it.xl_ok = 1'b0;
    send_req(it);
    for (int i = 0; i < 8; i++) begin
      it = mk(REQ_FILL, 22'h000abc);
      it.intent = INT_W'(i);
      send_req(it);
    end
    it = mk(REQ_FILL, 22'h3fffff);
    it.phys = 32'hffffffff;
    send_req(it);
    it = mk(REQ_FILL, 22'h001000);
    it.phys = 32'h0;
    send_req(it);
  endtask

  task automatic test_fixed_load();
    tlb_req_t it;
    it = mk(REQ_LOAD, {10'd1022, 12'h0});
    it.slot = 3'd7;
    it.count = 11'd4;
    send_req(it);
    it = mk(REQ_LOAD, {10'd5, 12'h0});
    it.slot = 3'd7;
    it.count = 11'd2;
    send_req(it);
    it = mk(REQ_LOAD, {10'd9, 12'h0});
    it.slot = 3'd3;
    it.count = 11'd0;
    send_req(it);
    it = mk(REQ_LOAD, {10'd200, 12'hfff});
    it.slot = 3'd0;
    it.count = 11'h7ff;
    it.lval = 32'hffffffff;
    send_req(it);
    it.count = 11'd1;
    it.lval = 32'h0;
    send_req(it);
    send_req(mk(REQ_LOOKUP, {10'd201, 12'h0}));
  endtask

  task automatic test_flush_and_odd_reqs();
    tlb_req_t it;
    send_req(mk(REQ_FILL, {10'd3, 12'h0}));
    send_req(mk(REQ_FLUSHP, {10'd3, 12'h0}));
    it = mk(REQ_LOAD, {10'd3, 12'h0});
    it.slot = 3'd1;
    it.count = 11'd1;
    send_req(it);
    send_req(mk(REQ_FLUSHD, {10'd3, 12'h0}));
    for (int r = 5; r < 8; r++) send_req(mk(3'(r), {10'd1022, 12'h0}));
  endtask

  task automatic test_dyn_count();
    logic [DC_W-1:0] vals [6] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd16};
    foreach (vals[j]) begin
      write_dyn_count(vals[j]);
      for (int i = 0; i < 4; i++) send_req(mk(REQ_FILL, {10'($urandom_range(20, 40)), 12'h0}));
    end
  endtask

  task automatic test_random(input int unsigned n, input int unsigned ip, input int unsigned sp);
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      send_req(rand_req());
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.req_type = '0;
    in_if.virt_address = '0;
    in_if.intention = '0;
    in_if.translate_ok = 1'b0;
    in_if.phys_address = '0;
    in_if.fixed_slot = '0;
    in_if.page_count = '0;
    in_if.load_value = '0;
    out_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    fails = 0;
    n_sent = 0;
    n_checked = 0;
    n_big = 0;
    foreach (pg_tbl[i]) pg_tbl[i] = '0;
    foreach (owner[i]) owner[i] = 0;
    foreach (span[i]) span[i] = 0;
    next_slot = 0;
    dyn_cnt = 32'(DC_RESET);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_lookup();
    test_fixed_load();
    test_flush_and_odd_reqs();
    test_dyn_count();
    test_random(100, 0, 0);
    write_dyn_count(5'($urandom_range(1, 5)));
    test_random(100, 46, 0);
    write_dyn_count(5'($urandom_range(6, 31)));
    test_random(100, 0, 46);
    write_dyn_count(5'd16);
    test_random(100, 13, 13);

    drain();
    repeat (2200) @(posedge clk);
    $display("covered fills, fixed loads, flushes and unknown requests under");
    $display("%0d dynamic-slot settings: %0d requests, %0d responses checked", 10, n_sent,
             n_checked);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
